### src/owbm_pkg.sv
// shared types and constants for the one-wire bus master
// phase codes, command kinds, register indexes and the result record
package owbm_pkg;

    localparam int PhaseWidth = 3;
    localparam logic [PhaseWidth-1:0] PH_IDLE       = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_RESET_LOW  = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_RESET_WAIT = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_RECOVER    = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_SLOT       = 3'd4;

    localparam logic [1:0] KIND_RESET = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 10;
    localparam logic [CfgIndexWidth-1:0] REG_RESET_LOW       = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_RESET_RECOVERY  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SLOT            = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SHORT_LOW       = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_LONG_LOW        = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_READ_SAMPLE     = 3'd6;

    localparam logic [9:0] RESET_LOW_DEFAULT       = 10'd480;
    localparam logic [7:0] PRESENCE_SAMPLE_DEFAULT = 8'd70;
    localparam logic [9:0] RESET_RECOVERY_DEFAULT  = 10'd410;
    localparam logic [7:0] SLOT_DEFAULT            = 8'd70;
    localparam logic [5:0] SHORT_LOW_DEFAULT       = 6'd6;
    localparam logic [7:0] LONG_LOW_DEFAULT        = 8'd60;
    localparam logic [7:0] READ_SAMPLE_DEFAULT     = 8'd15;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

endpackage

### src/onewire_bus_master.sv
// one-wire bus master: one request per microsecond tick, one result per request
// a taken request's result enters the output queue in the next cycle
// throughput: one request per cycle; a two-entry output queue keeps input open while
// a result waits, input stalls only when both entries are full
// reset (synchronous, active low): phase idle, counters and shift register cleared,
// timing registers back to their defaults, output queue empty
module onewire_bus_master #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd_valid,
    input  logic [1:0]                         i_kind,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_line_level,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_drive_low,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_presence,
    output logic [7:0]                         o_read_byte,
    output logic                               o_rejected,
    input  logic                               i_cfg_we,
    input  logic [owbm_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [owbm_pkg::CfgDataWidth-1:0]  i_cfg_data
);

    // timing registers
    logic [9:0] r_reset_low;
    logic [7:0] r_presence_sample;
    logic [9:0] r_reset_recovery;
    logic [7:0] r_slot;
    logic [5:0] r_short_low;
    logic [7:0] r_long_low;
    logic [7:0] r_read_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low       <= owbm_pkg::RESET_LOW_DEFAULT;
            r_presence_sample <= owbm_pkg::PRESENCE_SAMPLE_DEFAULT;
            r_reset_recovery  <= owbm_pkg::RESET_RECOVERY_DEFAULT;
            r_slot            <= owbm_pkg::SLOT_DEFAULT;
            r_short_low       <= owbm_pkg::SHORT_LOW_DEFAULT;
            r_long_low        <= owbm_pkg::LONG_LOW_DEFAULT;
            r_read_sample     <= owbm_pkg::READ_SAMPLE_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owbm_pkg::REG_RESET_LOW:       r_reset_low       <= i_cfg_data[9:0];
                owbm_pkg::REG_PRESENCE_SAMPLE: r_presence_sample <= i_cfg_data[7:0];
                owbm_pkg::REG_RESET_RECOVERY:  r_reset_recovery  <= i_cfg_data[9:0];
                owbm_pkg::REG_SLOT:            r_slot            <= i_cfg_data[7:0];
                owbm_pkg::REG_SHORT_LOW:       r_short_low       <= i_cfg_data[5:0];
                owbm_pkg::REG_LONG_LOW:        r_long_low        <= i_cfg_data[7:0];
                owbm_pkg::REG_READ_SAMPLE:     r_read_sample     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // bus state
    logic [owbm_pkg::PhaseWidth-1:0] r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]          r_count, n_count;
    logic [2:0]                      r_bit, n_bit;
    logic [7:0]                      r_shift, n_shift;
    logic [1:0]                      r_kind, n_kind;
    logic                            r_presence, n_presence;

    logic             in_accept;
    owbm_pkg::t_result result;

    // start-of-request view after a possible command launch
    logic [owbm_pkg::PhaseWidth-1:0] s_phase;
    logic [COUNT_WIDTH-1:0]          s_count;
    logic [2:0]                      s_bit;
    logic [7:0]                      s_shift;
    logic [1:0]                      s_kind;
    logic                            rej;

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [7:0]             slot_len;
    logic [7:0]             sample_at;
    logic [7:0]             low_len;
    logic [7:0]             shift_rd;
    logic [7:0]             shift_end;

    always_comb begin
        s_phase = r_phase;
        s_count = r_count;
        s_bit   = r_bit;
        s_shift = r_shift;
        s_kind  = r_kind;
        rej     = 1'b0;
        if (i_cmd_valid) begin
            if (r_phase != owbm_pkg::PH_IDLE || i_kind > owbm_pkg::KIND_READ) begin
                rej = 1'b1;
            end else begin
                s_kind  = i_kind;
                s_count = '0;
                s_bit   = '0;
                if (i_kind == owbm_pkg::KIND_RESET) begin
                    s_phase = owbm_pkg::PH_RESET_LOW;
                end else begin
                    s_phase = owbm_pkg::PH_SLOT;
                    s_shift = (i_kind == owbm_pkg::KIND_WRITE) ? i_data_byte : 8'd0;
                end
            end
        end
    end

    always_comb begin
        count_inc = s_count + COUNT_WIDTH'(1);
        slot_len  = (r_slot == 8'd0) ? 8'd1 : r_slot;
        sample_at = (r_read_sample < slot_len) ? r_read_sample : slot_len - 8'd1;
        low_len   = s_shift[0] ? {2'b00, r_short_low} : r_long_low;
        // read sample lands in the shift register before the slot end check
        shift_rd  = (s_count == COUNT_WIDTH'(sample_at))
                    ? {i_line_level, s_shift[7:1]} : s_shift;
        shift_end = (s_kind == owbm_pkg::KIND_WRITE) ? {1'b0, s_shift[7:1]} : shift_rd;
    end

    always_comb begin
        n_phase    = s_phase;
        n_count    = s_count;
        n_bit      = s_bit;
        n_shift    = s_shift;
        n_kind     = s_kind;
        n_presence = r_presence;
        result     = '0;
        result.rejected = rej;

        unique case (s_phase)
            owbm_pkg::PH_RESET_LOW: begin
                result.drive_low = 1'b1;
                if (count_inc >= COUNT_WIDTH'(r_reset_low)) begin
                    n_phase = owbm_pkg::PH_RESET_WAIT;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            owbm_pkg::PH_RESET_WAIT: begin
                if (s_count >= COUNT_WIDTH'(r_presence_sample)) begin
                    n_presence = ~i_line_level;
                    n_count    = '0;
                    if (r_reset_recovery == 10'd0) begin
                        n_phase         = owbm_pkg::PH_IDLE;
                        result.done_res = 1'b1;
                    end else begin
                        n_phase = owbm_pkg::PH_RECOVER;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            owbm_pkg::PH_RECOVER: begin
                if (count_inc >= COUNT_WIDTH'(r_reset_recovery)) begin
                    n_phase         = owbm_pkg::PH_IDLE;
                    n_count         = '0;
                    result.done_res = 1'b1;
                end else begin
                    n_count = count_inc;
                end
            end
            owbm_pkg::PH_SLOT: begin
                if (s_kind == owbm_pkg::KIND_WRITE) begin
                    result.drive_low = (s_count < COUNT_WIDTH'(low_len));
                end else begin
                    result.drive_low = (s_count < COUNT_WIDTH'(r_short_low));
                    n_shift          = shift_rd;
                end
                if (count_inc >= COUNT_WIDTH'(slot_len)) begin
                    n_count = '0;
                    n_shift = shift_end;
                    if (s_bit == owbm_pkg::LAST_BIT) begin
                        n_bit           = '0;
                        n_phase         = owbm_pkg::PH_IDLE;
                        result.done_res = 1'b1;
                        if (s_kind == owbm_pkg::KIND_READ) begin
                            result.read_byte = shift_end;
                        end
                    end else begin
                        n_bit = s_bit + 3'd1;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            default: ;
        endcase

        result.busy_res = (n_phase != owbm_pkg::PH_IDLE);
        result.presence = n_presence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= owbm_pkg::PH_IDLE;
            r_count    <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_kind     <= '0;
            r_presence <= 1'b0;
        end else if (in_accept) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_kind     <= n_kind;
            r_presence <= n_presence;
        end
    end

    // two-entry output queue: head drives the ports, second entry is the skid
    owbm_pkg::t_result r_head, r_skid;
    logic              r_head_valid, r_skid_valid;
    logic              out_pop;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_pop    = r_head_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (r_head_valid) begin
                if (in_accept && !out_pop) begin
                    r_skid_valid <= 1'b1;
                end else if (!in_accept && out_pop) begin
                    r_head_valid <= 1'b0;
                end
            end else if (in_accept) begin
                r_head_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_head <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_head_valid || out_pop) begin
                r_head <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_out_valid = r_head_valid;
    assign o_drive_low = r_head.drive_low;
    assign o_busy_res  = r_head.busy_res;
    assign o_done_res  = r_head.done_res;
    assign o_presence  = r_head.presence;
    assign o_read_byte = r_head.read_byte;
    assign o_rejected  = r_head.rejected;

endmodule
